/* rtl/core/omp_pkg.sv */
// Shared types, constants and register indexes for the orientation motion presence detector.
`default_nettype none
package omp_pkg;

    localparam int unsigned DEF_WINDOW_DEPTH   = 128;
    localparam int unsigned DEF_MIN_FILL       = 8;
    localparam int unsigned DEF_QUAT_FRAC_BITS = 14;

    localparam int unsigned QUAT_W  = 16;
    localparam int unsigned FRAME_W = 4 * QUAT_W;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned COS_W   = 15;
    localparam int unsigned MS_W    = 16;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CIDX_W  = 2;

    localparam logic [COS_W-1:0] RST_HELD_COS   = 15'd16378;
    localparam logic [COS_W-1:0] RST_IDLE_COS   = 15'd16362;
    localparam logic [MS_W-1:0]  RST_PICKUP_MS  = 16'd300;
    localparam logic [MS_W-1:0]  RST_PUTDOWN_MS = 16'd1000;

    localparam logic [CIDX_W-1:0] CFG_HELD_COS   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_IDLE_COS   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_PICKUP_MS  = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_PUTDOWN_MS = 2'd3;

    // per-stage request flags
    typedef struct packed {
        logic valid;
        logic has_old;
        logic full;
    } t_flags;

endpackage
`default_nettype wire

/* rtl/core/orientation_motion_presence_detector_top.sv */
// Top level of the orientation motion presence detector.
// One quaternion frame (signed Q1.14 per component) and a millisecond stamp go in per request,
// one result comes out per request. The path is four register stages deep: window memory read,
// four parallel component products, sum/abs/scale/clamp, then the held/released timers and the
// result register. One request is accepted every cycle while the receiver keeps i_ready high;
// the window memory has one write port and one registered read port, and each request uses each
// once in its accept cycle. The held state updates in the final stage only, so consecutive
// frames are judged in order with no stall. Configuration writes take effect on the next edge
// and may be issued at any time the block is idle.
`default_nettype none
module orientation_motion_presence_detector_top #(
    parameter int unsigned WINDOW_DEPTH   = omp_pkg::DEF_WINDOW_DEPTH,
    parameter int unsigned MIN_FILL       = omp_pkg::DEF_MIN_FILL,
    parameter int unsigned QUAT_FRAC_BITS = omp_pkg::DEF_QUAT_FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [omp_pkg::CIDX_W-1:0]    i_cfg_index,
    input  wire logic [omp_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [15:0]            i_quat_w,
    input  wire logic signed [15:0]            i_quat_x,
    input  wire logic signed [15:0]            i_quat_y,
    input  wire logic signed [15:0]            i_quat_z,
    input  wire logic [31:0]                   i_stamp_ms,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_is_held,
    output logic [14:0]                        o_abs_cosine,
    output logic                               o_window_full
);
    import omp_pkg::*;

    t_flags                  w_f1, w_f3;
    logic [FRAME_W-1:0]      w_frame_in, w_frame1, w_old1;
    logic [STAMP_W-1:0]      w_stamp1, w_stamp3;
    logic [QUAT_FRAC_BITS:0] w_cos3;
    logic                    w_rdy2, w_rdy4;

    assign w_frame_in = {i_quat_z, i_quat_y, i_quat_x, i_quat_w};

    omp_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .MIN_FILL     (MIN_FILL)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_frame    (w_frame_in),
        .i_stamp    (i_stamp_ms),
        .i_dn_ready (w_rdy2),
        .o_flags    (w_f1),
        .o_frame    (w_frame1),
        .o_old      (w_old1),
        .o_stamp    (w_stamp1)
    );

    omp_cosine #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_cosine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_flags    (w_f1),
        .i_frame    (w_frame1),
        .i_old      (w_old1),
        .i_stamp    (w_stamp1),
        .o_ready    (w_rdy2),
        .i_dn_ready (w_rdy4),
        .o_flags    (w_f3),
        .o_cos      (w_cos3),
        .o_stamp    (w_stamp3)
    );

    omp_judge #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_judge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_flags       (w_f3),
        .i_cos         (w_cos3),
        .i_stamp       (w_stamp3),
        .o_up_ready    (w_rdy4),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_is_held     (o_is_held),
        .o_abs_cosine  (o_abs_cosine),
        .o_window_full (o_window_full)
    );

endmodule
`default_nettype wire

/* rtl/core/omp_window.sv */
// Frame ring memory, write slot and fill count; first pipeline stage.
`default_nettype none
module omp_window #(
    parameter int unsigned WINDOW_DEPTH = omp_pkg::DEF_WINDOW_DEPTH,
    parameter int unsigned MIN_FILL     = omp_pkg::DEF_MIN_FILL
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [omp_pkg::FRAME_W-1:0]   i_frame,
    input  wire logic [omp_pkg::STAMP_W-1:0]   i_stamp,
    input  wire logic                          i_dn_ready,
    output omp_pkg::t_flags                    o_flags,
    output logic [omp_pkg::FRAME_W-1:0]        o_frame,
    output logic [omp_pkg::FRAME_W-1:0]        o_old,
    output logic [omp_pkg::STAMP_W-1:0]        o_stamp
);
    import omp_pkg::*;

    localparam int unsigned AW = $clog2(WINDOW_DEPTH);
    localparam int unsigned FW = $clog2(WINDOW_DEPTH + 1);

    logic [FRAME_W-1:0] r_mem [WINDOW_DEPTH];
    logic [AW-1:0]      r_wr_slot, n_wr_slot;
    logic [FW-1:0]      r_fill, n_fill;
    t_flags             r_flags;
    logic [FRAME_W-1:0] r_frame, r_old;
    logic [STAMP_W-1:0] r_stamp;

    logic          w_en, w_accept, w_full, w_full_after, w_has_old;
    logic [AW-1:0] w_rd_addr;

    assign w_en     = !r_flags.valid || i_dn_ready;
    assign w_accept = i_valid && w_en;
    assign o_ready  = w_en;

    assign w_full       = (r_fill == FW'(WINDOW_DEPTH));
    assign w_full_after = w_full || (r_fill == FW'(WINDOW_DEPTH - 1));
    assign w_has_old    = (32'(r_fill) >= 32'(MIN_FILL));
    // until full the oldest frame sits in slot zero; after that it is the one overwritten now
    assign w_rd_addr    = w_full ? r_wr_slot : '0;

    always_comb begin
        n_wr_slot = r_wr_slot;
        n_fill    = r_fill;
        if (w_accept) begin
            n_wr_slot = (r_wr_slot == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wr_slot + 1'b1;
            if (!w_full) begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem[r_wr_slot] <= i_frame;
        end
        if (w_en) begin
            r_old   <= r_mem[w_rd_addr];
            r_frame <= i_frame;
            r_stamp <= i_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_slot <= '0;
            r_fill    <= '0;
            r_flags   <= '0;
        end else begin
            r_wr_slot <= n_wr_slot;
            r_fill    <= n_fill;
            if (w_en) begin
                r_flags.valid   <= w_accept;
                r_flags.has_old <= w_has_old;
                r_flags.full    <= w_full_after;
            end
        end
    end

    assign o_flags = r_flags;
    assign o_frame = r_frame;
    assign o_old   = r_old;
    assign o_stamp = r_stamp;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= 32'(WINDOW_DEPTH))
        else $error("fill count above window depth");
    a_slot_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_full |-> (FW'(r_wr_slot) == r_fill))
        else $error("write slot out of step with fill count");
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_full) |=> (r_fill == $past(r_fill) + 1'b1))
        else $error("fill count missed a request");
`endif

endmodule
`default_nettype wire

/* rtl/core/omp_cosine.sv */
// Dot product with the window-old frame: products stage, then sum, abs, scale and clamp stage.
`default_nettype none
module omp_cosine #(
    parameter int unsigned QUAT_FRAC_BITS = omp_pkg::DEF_QUAT_FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  omp_pkg::t_flags                    i_flags,
    input  wire logic [omp_pkg::FRAME_W-1:0]   i_frame,
    input  wire logic [omp_pkg::FRAME_W-1:0]   i_old,
    input  wire logic [omp_pkg::STAMP_W-1:0]   i_stamp,
    output logic                               o_ready,
    input  wire logic                          i_dn_ready,
    output omp_pkg::t_flags                    o_flags,
    output logic [QUAT_FRAC_BITS:0]            o_cos,
    output logic [omp_pkg::STAMP_W-1:0]        o_stamp
);
    import omp_pkg::*;

    localparam int unsigned CW = QUAT_FRAC_BITS + 1;
    localparam logic [32:0] Q_ONE = 33'd1 << QUAT_FRAC_BITS;

    t_flags                r_f2, r_f3;
    logic signed [31:0]    r_prod [4];
    logic [STAMP_W-1:0]    r_stamp2, r_stamp3;
    logic [CW-1:0]         r_cos;

    logic                  w_en2, w_en3;
    logic signed [33:0]    w_sum, w_abs;
    logic [32:0]           w_scaled, w_clamped;

    assign w_en3   = !r_f3.valid || i_dn_ready;
    assign w_en2   = !r_f2.valid || w_en3;
    assign o_ready = w_en2;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            for (int k = 0; k < 4; k++) begin
                r_prod[k] <= $signed(i_frame[QUAT_W*k +: QUAT_W])
                           * $signed(i_old[QUAT_W*k +: QUAT_W]);
            end
            r_stamp2 <= i_stamp;
        end
        if (w_en3) begin
            r_cos    <= r_f2.has_old ? CW'(w_clamped) : CW'(Q_ONE);
            r_stamp3 <= r_stamp2;
        end
    end

    always_comb begin
        w_sum     = 34'(r_prod[0]) + 34'(r_prod[1]) + 34'(r_prod[2]) + 34'(r_prod[3]);
        w_abs     = w_sum[33] ? -w_sum : w_sum;
        w_scaled  = w_abs[32:0] >> QUAT_FRAC_BITS;
        w_clamped = (w_scaled > Q_ONE) ? Q_ONE : w_scaled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2 <= '0;
            r_f3 <= '0;
        end else begin
            if (w_en2) begin
                r_f2 <= i_flags;
            end
            if (w_en3) begin
                r_f3 <= r_f2;
            end
        end
    end

    assign o_flags = r_f3;
    assign o_cos   = r_cos;
    assign o_stamp = r_stamp3;

endmodule
`default_nettype wire

/* rtl/core/omp_judge.sv */
// Configuration registers, held/released timers and the result register.
`default_nettype none
module omp_judge #(
    parameter int unsigned QUAT_FRAC_BITS = omp_pkg::DEF_QUAT_FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [omp_pkg::CIDX_W-1:0]    i_cfg_index,
    input  wire logic [omp_pkg::CFG_W-1:0]     i_cfg_data,
    input  omp_pkg::t_flags                    i_flags,
    input  wire logic [QUAT_FRAC_BITS:0]       i_cos,
    input  wire logic [omp_pkg::STAMP_W-1:0]   i_stamp,
    output logic                               o_up_ready,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_is_held,
    output logic [omp_pkg::COS_W-1:0]          o_abs_cosine,
    output logic                               o_window_full
);
    import omp_pkg::*;

    localparam int unsigned CW    = QUAT_FRAC_BITS + 1;
    localparam int unsigned CMP_W = (CW > COS_W) ? CW : COS_W;

    logic [COS_W-1:0]   r_held_cos, r_idle_cos;
    logic [MS_W-1:0]    r_pickup_ms, r_putdown_ms;
    logic               r_held, n_held;
    logic [STAMP_W-1:0] r_motion_start, n_motion_start;
    logic [STAMP_W-1:0] r_still_start, n_still_start;
    logic               r_out_valid, r_out_held, r_out_full;
    logic [COS_W-1:0]   r_out_cos;

    logic               w_take, w_fire, w_moving;
    logic [COS_W-1:0]   w_thr;
    logic [STAMP_W-1:0] w_motion_age, w_still_age;

    assign w_take     = !r_out_valid || i_ready;
    assign w_fire     = i_flags.valid && w_take;
    assign o_up_ready = w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cos   <= RST_HELD_COS;
            r_idle_cos   <= RST_IDLE_COS;
            r_pickup_ms  <= RST_PICKUP_MS;
            r_putdown_ms <= RST_PUTDOWN_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HELD_COS:   r_held_cos   <= i_cfg_data[COS_W-1:0];
                CFG_IDLE_COS:   r_idle_cos   <= i_cfg_data[COS_W-1:0];
                CFG_PICKUP_MS:  r_pickup_ms  <= i_cfg_data[MS_W-1:0];
                CFG_PUTDOWN_MS: r_putdown_ms <= i_cfg_data[MS_W-1:0];
            endcase
        end
    end

    assign w_thr        = r_held ? r_held_cos : r_idle_cos;
    assign w_moving     = CMP_W'(i_cos) < CMP_W'(w_thr);
    assign w_motion_age = i_stamp - r_motion_start;
    assign w_still_age  = i_stamp - r_still_start;

    // a start stamp of zero means the timer is unarmed
    always_comb begin
        n_held         = r_held;
        n_motion_start = r_motion_start;
        n_still_start  = r_still_start;
        if (w_fire && i_flags.full) begin
            if (!r_held) begin
                if (!w_moving) begin
                    n_motion_start = '0;
                end else if (r_motion_start == '0) begin
                    n_motion_start = i_stamp;
                end else if (w_motion_age >= STAMP_W'(r_pickup_ms)) begin
                    n_held         = 1'b1;
                    n_motion_start = '0;
                    n_still_start  = '0;
                end
            end else begin
                if (w_moving) begin
                    n_still_start = '0;
                end else if (r_still_start == '0) begin
                    n_still_start = i_stamp;
                end else if (w_still_age >= STAMP_W'(r_putdown_ms)) begin
                    n_held        = 1'b0;
                    n_still_start = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held         <= 1'b0;
            r_motion_start <= '0;
            r_still_start  <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_held         <= n_held;
            r_motion_start <= n_motion_start;
            r_still_start  <= n_still_start;
            if (w_take) begin
                r_out_valid <= i_flags.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_held <= n_held;
            r_out_cos  <= COS_W'(i_cos);
            r_out_full <= i_flags.full;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_is_held     = r_out_held;
    assign o_abs_cosine  = r_out_cos;
    assign o_window_full = r_out_full;

`ifndef NO_ASSERTIONS
    a_held_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held != $past(r_held)) |-> $past(w_fire && i_flags.full))
        else $error("held flag moved without a full-window request");
    a_pickup_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_held) |-> (r_motion_start == '0 && r_still_start == '0))
        else $error("timers left armed on pickup");
    a_held_no_motion_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held |-> (r_motion_start == '0))
        else $error("motion timer armed while held");
    a_result_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_fire) |-> (r_out_held == r_held))
        else $error("result held bit differs from held state");
`endif

endmodule
`default_nettype wire

/* verif/omp_result_scoreboard.sv */
// Scoreboard for the presence detector: mirrors window, timers and registers, checks results.
module omp_result_scoreboard (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [omp_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [omp_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic signed [15:0]          i_quat_w,
    input  logic signed [15:0]          i_quat_x,
    input  logic signed [15:0]          i_quat_y,
    input  logic signed [15:0]          i_quat_z,
    input  logic [31:0]                 i_stamp_ms,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic                        i_is_held,
    input  logic [14:0]                 i_abs_cosine,
    input  logic                        i_window_full,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked,
    output int                          o_held_toggles
);
    import omp_pkg::*;

    localparam int unsigned DEPTH       = DEF_WINDOW_DEPTH;
    localparam int unsigned MIN_STORED  = DEF_MIN_FILL;
    localparam int unsigned FRAC        = DEF_QUAT_FRAC_BITS;
    localparam longint      Q_UNITY     = longint'(1) << FRAC;
    localparam int          MAX_REPORTS = 200;

    typedef struct packed {
        logic             held;
        logic [COS_W-1:0] cosine;
        logic             full;
    } t_verdict;

    t_verdict expected_verdicts[$];

    logic [FRAME_W-1:0] frame_ring [DEPTH];
    int unsigned        next_slot;
    int unsigned        stored;
    logic               held;
    logic [STAMP_W-1:0] motion_t0;
    logic [STAMP_W-1:0] still_t0;

    logic [COS_W-1:0]   held_cos;
    logic [COS_W-1:0]   idle_cos;
    logic [MS_W-1:0]    pickup;
    logic [MS_W-1:0]    putdown;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (o_fail_count < MAX_REPORTS) begin
            $display("mismatch on result %0d: %s expected %0d got %0d",
                     o_checked, what, want, got);
        end
        o_fail_count++;
    endtask

    // Advance the mirror by one frame and return the verdict the block should give.
    function automatic t_verdict predict_verdict(input logic [FRAME_W-1:0] frame,
                                                 input logic [STAMP_W-1:0] now);
        logic [FRAME_W-1:0] old_frame;
        logic signed [15:0] a;
        logic signed [15:0] b;
        longint             dot;
        longint             cosv;
        logic               moving;
        logic               was_held;
        t_verdict           v;

        cosv = Q_UNITY;
        if (stored >= MIN_STORED) begin
            old_frame = frame_ring[(next_slot + DEPTH - stored) % DEPTH];
            dot = 0;
            for (int k = 0; k < 4; k++) begin
                a = frame[16*k +: 16];
                b = old_frame[16*k +: 16];
                dot += longint'(a) * longint'(b);
            end
            // abs first, then truncate, then clamp to one
            if (dot < 0) dot = -dot;
            dot = dot >> FRAC;
            cosv = (dot > Q_UNITY) ? Q_UNITY : dot;
        end

        frame_ring[next_slot] = frame;
        next_slot = (next_slot + 1) % DEPTH;
        if (stored < DEPTH) stored++;

        was_held = held;
        if (stored >= DEPTH) begin
            moving = cosv < longint'(held ? held_cos : idle_cos);
            if (!held) begin
                if (!moving) begin
                    motion_t0 = '0;
                end else if (motion_t0 == '0) begin
                    motion_t0 = now;
                end else if (STAMP_W'(now - motion_t0) >= pickup) begin
                    held      = 1'b1;
                    motion_t0 = '0;
                    still_t0  = '0;
                end
            end else begin
                if (moving) begin
                    still_t0 = '0;
                end else if (still_t0 == '0) begin
                    still_t0 = now;
                end else if (STAMP_W'(now - still_t0) >= putdown) begin
                    held     = 1'b0;
                    still_t0 = '0;
                end
            end
        end
        if (held != was_held) o_held_toggles++;

        v.held   = held;
        v.cosine = cosv[COS_W-1:0];
        v.full   = stored >= DEPTH;
        return v;
    endfunction

    always @(posedge i_clk) begin : watch
        t_verdict want;
        if (!i_rst_n) begin
            expected_verdicts.delete();
            next_slot      = 0;
            stored         = 0;
            held           = 1'b0;
            motion_t0      = '0;
            still_t0       = '0;
            held_cos       = RST_HELD_COS;
            idle_cos       = RST_IDLE_COS;
            pickup         = RST_PICKUP_MS;
            putdown        = RST_PUTDOWN_MS;
            o_fail_count   = 0;
            o_checked      = 0;
            o_held_toggles = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HELD_COS:   held_cos = i_cfg_data[COS_W-1:0];
                    CFG_IDLE_COS:   idle_cos = i_cfg_data[COS_W-1:0];
                    CFG_PICKUP_MS:  pickup   = i_cfg_data[MS_W-1:0];
                    CFG_PUTDOWN_MS: putdown  = i_cfg_data[MS_W-1:0];
                    default: ;
                endcase
            end
            // a result never belongs to a request accepted on the same edge
            if (i_out_valid && i_out_ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch("result with no request outstanding", 0, 1);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (i_is_held !== want.held)
                        report_mismatch("is_held", want.held, i_is_held);
                    if (i_abs_cosine !== want.cosine)
                        report_mismatch("abs_cosine", want.cosine, i_abs_cosine);
                    if (i_window_full !== want.full)
                        report_mismatch("window_full", want.full, i_window_full);
                end
                o_checked++;
            end
            if (i_in_valid && i_in_ready) begin
                expected_verdicts.push_back(predict_verdict(
                    {i_quat_z, i_quat_y, i_quat_x, i_quat_w}, i_stamp_ms));
            end
        end
        o_pending = expected_verdicts.size();
    end

endmodule

/* verif/orientation_motion_presence_detector_top_tb.sv */
// Testbench top for the presence detector: frame and register stimulus, flow control and verdict.
module orientation_motion_presence_detector_top_tb;
    import omp_pkg::*;

    localparam int DIRECTED_COUNT  = 20;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int LONG_HOLD       = 300;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_CYCLES    = 16;

    typedef struct packed {
        logic [15:0] w;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [31:0] stamp;
    } t_frame;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [CIDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic signed [15:0] quat_w    = '0;
    logic signed [15:0] quat_x    = '0;
    logic signed [15:0] quat_y    = '0;
    logic signed [15:0] quat_z    = '0;
    logic [31:0]        stamp_ms  = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               is_held;
    logic [14:0]        abs_cosine;
    logic               window_full;

    int fail_count;
    int pending;
    int checked;
    int held_toggles;

    // stimulus state
    logic signed [15:0] pose [4];
    logic [31:0]        stamp_now     = '0;
    logic               seg_moving    = 1'b0;
    int                 seg_left      = 0;
    int                 drift         = 100;
    logic               idle_on       = 1'b1;
    int                 hold_requests = 0;
    int                 frames_sent   = 0;
    int                 settings_applied = 0;
    int                 quiet_cycles  = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    orientation_motion_presence_detector_top uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_valid       (in_valid),
        .o_ready       (in_ready),
        .i_quat_w      (quat_w),
        .i_quat_x      (quat_x),
        .i_quat_y      (quat_y),
        .i_quat_z      (quat_z),
        .i_stamp_ms    (stamp_ms),
        .o_valid       (out_valid),
        .i_ready       (out_ready),
        .o_is_held     (is_held),
        .o_abs_cosine  (abs_cosine),
        .o_window_full (window_full)
    );

    omp_result_scoreboard u_scoreboard (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_quat_w       (quat_w),
        .i_quat_x       (quat_x),
        .i_quat_y       (quat_y),
        .i_quat_z       (quat_z),
        .i_stamp_ms     (stamp_ms),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_is_held      (is_held),
        .i_abs_cosine   (abs_cosine),
        .i_window_full  (window_full),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_held_toggles (held_toggles)
    );

    function automatic t_frame mk_frame(input int w, input int x, input int y, input int z,
                                        input logic [31:0] st);
        t_frame f;
        f.w     = w[15:0];
        f.x     = x[15:0];
        f.y     = y[15:0];
        f.z     = z[15:0];
        f.stamp = st;
        return f;
    endfunction

    // Segments of stillness (one pose plus jitter) and motion (drifting pose), with rare noise.
    function automatic t_frame next_random_frame();
        t_frame             f;
        logic signed [15:0] q [4];
        int                 axis;
        int                 val;
        int                 roll;

        if (seg_left == 0) begin
            seg_moving = ($urandom_range(0, 2) == 0);
            seg_left   = seg_moving ? $urandom_range(10, 120) : $urandom_range(60, 320);
            drift      = $urandom_range(20, 1500);
            if (!seg_moving) begin
                axis = $urandom_range(0, 3);
                for (int k = 0; k < 4; k++) begin
                    if (k == axis) val = $urandom_range(0, 1) ? 16384 : -16384;
                    else val = int'($urandom_range(0, 4000)) - 2000;
                    pose[k] = val[15:0];
                end
            end
        end
        seg_left--;

        roll = $urandom_range(0, 99);
        for (int k = 0; k < 4; k++) begin
            if (seg_moving) begin
                val = int'(pose[k]) + int'($urandom_range(0, 2 * drift)) - drift;
                if (val > 16384) val = 16384;
                if (val < -16384) val = -16384;
                pose[k] = val[15:0];
            end
            if (roll < 3) begin
                q[k] = 16'($urandom);
            end else if (seg_moving) begin
                q[k] = pose[k];
            end else begin
                val  = int'(pose[k]) + int'($urandom_range(0, 4)) - 2;
                q[k] = val[15:0];
            end
        end

        roll = $urandom_range(0, 99);
        if (roll < 2) stamp_now = '0;
        else if (roll < 3) stamp_now = $urandom;
        else if (roll < 4) stamp_now = 32'hFFFF_FFFF - $urandom_range(0, 200);
        else stamp_now = stamp_now + $urandom_range(0, 25);

        f.w     = q[0];
        f.x     = q[1];
        f.y     = q[2];
        f.z     = q[3];
        f.stamp = stamp_now;
        return f;
    endfunction

    task automatic send_frame(input t_frame f);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        quat_w   <= f.w;
        quat_x   <= f.x;
        quat_y   <= f.y;
        quat_z   <= f.z;
        stamp_ms <= f.stamp;
        do @(posedge clk); while (!in_ready);
        frames_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] h_cos, input logic [CFG_W-1:0] i_cos,
                                input logic [CFG_W-1:0] up_ms, input logic [CFG_W-1:0] down_ms);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HELD_COS;
        cfg_data  <= h_cos;
        @(negedge clk);
        cfg_index <= CFG_IDLE_COS;
        cfg_data  <= i_cos;
        @(negedge clk);
        cfg_index <= CFG_PICKUP_MS;
        cfg_data  <= up_ms;
        @(negedge clk);
        cfg_index <= CFG_PUTDOWN_MS;
        cfg_data  <= down_ms;
        @(negedge clk);
        cfg_we    <= 1'b0;
        settings_applied++;
    endtask

    // receiver: random stalls per result, plus a long hold-off when asked for
    initial begin
        int stall;
        int holds_done;
        holds_done = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_requests > holds_done) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                holds_done++;
            end else begin
                stall = idle_on ? $urandom_range(0, 8) : 0;
                if (stall > 0) begin
                    out_ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no request moved for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        t_frame f;
        logic [CFG_W-1:0] h_cos;
        logic [CFG_W-1:0] i_cos;
        logic [CFG_W-1:0] up_ms;
        logic [CFG_W-1:0] down_ms;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        program_regs(RST_HELD_COS, RST_IDLE_COS, RST_PICKUP_MS, RST_PUTDOWN_MS);

        // Field extremes first; frames 8 and on compare against frame 0 (a unit quaternion).
        for (int n = 0; n < DIRECTED_COUNT; n++) begin
            case (n)
                0:  f = mk_frame(8192, 8192, 8192, 8192, 32'h0000_0000);
                1:  f = mk_frame(-16384, 0, 0, 0, 32'hFFFF_FFFF);
                2:  f = mk_frame(0, 16384, 0, 0, 32'h8000_0000);
                3:  f = mk_frame(0, 0, -16384, 0, 32'h0000_0001);
                4:  f = mk_frame(0, 0, 0, 16384, 32'h0000_0000);
                5:  f = mk_frame(32767, -32768, 32767, -32768, 32'h7FFF_FFFF);
                6:  f = mk_frame(-32768, 32767, -32768, 32767, 32'h5555_5555);
                7:  f = mk_frame(21845, -21846, 21845, -21846, 32'hAAAA_AAAA);
                8:  f = mk_frame(-8192, -8192, -8192, -8192, 32'd100);  // q versus -q
                9:  f = mk_frame(8192, 8192, 8192, 8192, 32'd110);
                10: f = mk_frame(0, 0, 0, 0, 32'd120);
                11: f = mk_frame(16384, -16384, 16384, -16384, 32'd130);
                12: f = mk_frame(32767, 32767, 32767, 32767, 32'd140);
                13: f = mk_frame(-32768, -32768, -32768, -32768, 32'd150);  // clamp, wide sum
                14: f = mk_frame(1, 1, 1, 1, 32'd160);
                15: f = mk_frame(1, 0, 0, 0, 32'd170);
                16: f = mk_frame(-3, 0, 0, 0, 32'd180);  // abs taken before the shift
                17: f = mk_frame(16384, 0, 0, 0, 32'd190);
                18: f = mk_frame(11585, 11585, 0, 0, 32'd200);
                default: f = mk_frame(0, 0, 0, -16383, 32'd210);
            endcase
            send_frame(f);
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p)
                0: program_regs(16378, 16362, 300, 1000);
                1: program_regs(16200, 15800, 40, 120);
                2: program_regs(16'hFFFF, 16385, 0, 0);     // every frame is motion
                3: program_regs(0, 0, 0, 0);                // no frame is motion
                4: program_regs(16384, 16384, 65535, 65535);
                5: program_regs(16380, 16370, 0, 25);
                default: begin
                    h_cos   = CFG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                                 : $urandom_range(15500, 16400));
                    i_cos   = CFG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                                 : $urandom_range(15500, 16400));
                    up_ms   = CFG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                                 : $urandom_range(0, 400));
                    down_ms = CFG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                                 : $urandom_range(0, 400));
                    program_regs(h_cos, i_cos, up_ms, down_ms);
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
                // back up the pipeline while frames keep coming
                if (p == 1 && n == 20) hold_requests++;
                send_frame(next_random_frame());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d frames sent, %0d results checked under %0d register settings",
                 frames_sent, checked, settings_applied);
        $display("held flag changed %0d times across fill, wrap, stalls and timer extremes",
                 held_toggles);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/omp_pkg.sv
rtl/core/omp_window.sv
rtl/core/omp_cosine.sv
rtl/core/omp_judge.sv
rtl/core/orientation_motion_presence_detector_top.sv
verif/omp_result_scoreboard.sv
verif/orientation_motion_presence_detector_top_tb.sv
